/* hw/rtl/sha256_stream_hasher_assert.svh */
// Assertion macros for the SHA-256 stream hasher
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define SHA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication
`define SHA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* hw/rtl/sha_pkg.sv */
// Types, constants and round functions for the SHA-256 stream hasher
package sha_pkg;
	localparam logic [1:0] OP_ABSORB = 2'd0;
	localparam logic [1:0] OP_ABSORB_FINISH = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef logic [31:0] word_t;

	// datapath commands
	typedef struct packed {
		logic       load_byte;  // store in_byte at pending position, add 8 bits
		logic       pad_write;  // write padding byte at pad_idx
		logic       pad_len;    // padding write takes the length byte for pad_idx
		logic       start;      // load working vars from hash words
		logic       round;      // one compression round
		logic       fold;       // add working vars into hash words
		logic       reset_hash; // back to initial values
	} sha_cmd_t;

	typedef struct packed {
		logic [5:0] used;       // pending byte count
		logic       last_round;
	} sha_status_t;

	localparam word_t [7:0] INIT_HASH = '{
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	function automatic word_t round_k(input logic [5:0] r);
		word_t k;
		unique case (r)
		6'd0: k=32'h428a2f98; 6'd1: k=32'h71374491; 6'd2: k=32'hb5c0fbcf; 6'd3: k=32'he9b5dba5;
		6'd4: k=32'h3956c25b; 6'd5: k=32'h59f111f1; 6'd6: k=32'h923f82a4; 6'd7: k=32'hab1c5ed5;
		6'd8: k=32'hd807aa98; 6'd9: k=32'h12835b01; 6'd10: k=32'h243185be; 6'd11: k=32'h550c7dc3;
		6'd12: k=32'h72be5d74; 6'd13: k=32'h80deb1fe; 6'd14: k=32'h9bdc06a7; 6'd15: k=32'hc19bf174;
		6'd16: k=32'he49b69c1; 6'd17: k=32'hefbe4786; 6'd18: k=32'h0fc19dc6; 6'd19: k=32'h240ca1cc;
		6'd20: k=32'h2de92c6f; 6'd21: k=32'h4a7484aa; 6'd22: k=32'h5cb0a9dc; 6'd23: k=32'h76f988da;
		6'd24: k=32'h983e5152; 6'd25: k=32'ha831c66d; 6'd26: k=32'hb00327c8; 6'd27: k=32'hbf597fc7;
		6'd28: k=32'hc6e00bf3; 6'd29: k=32'hd5a79147; 6'd30: k=32'h06ca6351; 6'd31: k=32'h14292967;
		6'd32: k=32'h27b70a85; 6'd33: k=32'h2e1b2138; 6'd34: k=32'h4d2c6dfc; 6'd35: k=32'h53380d13;
		6'd36: k=32'h650a7354; 6'd37: k=32'h766a0abb; 6'd38: k=32'h81c2c92e; 6'd39: k=32'h92722c85;
		6'd40: k=32'ha2bfe8a1; 6'd41: k=32'ha81a664b; 6'd42: k=32'hc24b8b70; 6'd43: k=32'hc76c51a3;
		6'd44: k=32'hd192e819; 6'd45: k=32'hd6990624; 6'd46: k=32'hf40e3585; 6'd47: k=32'h106aa070;
		6'd48: k=32'h19a4c116; 6'd49: k=32'h1e376c08; 6'd50: k=32'h2748774c; 6'd51: k=32'h34b0bcb5;
		6'd52: k=32'h391c0cb3; 6'd53: k=32'h4ed8aa4a; 6'd54: k=32'h5b9cca4f; 6'd55: k=32'h682e6ff3;
		6'd56: k=32'h748f82ee; 6'd57: k=32'h78a5636f; 6'd58: k=32'h84c87814; 6'd59: k=32'h8cc70208;
		6'd60: k=32'h90befffa; 6'd61: k=32'ha4506ceb; 6'd62: k=32'hbef9a3f7; default: k=32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t ror(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage

/* hw/rtl/sha_if.sv */
// Valid/ready stream interfaces for input items and digests
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] message_byte;
	modport source (output valid, operation, message_byte, input ready);
	modport sink (input valid, operation, message_byte, output ready);
endinterface

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word_0;
	logic [31:0] digest_word_1;
	logic [31:0] digest_word_2;
	logic [31:0] digest_word_3;
	logic [31:0] digest_word_4;
	logic [31:0] digest_word_5;
	logic [31:0] digest_word_6;
	logic [31:0] digest_word_7;
	modport source (output valid, digest_word_0, digest_word_1, digest_word_2, digest_word_3,
		digest_word_4, digest_word_5, digest_word_6, digest_word_7, input ready);
	modport sink (input valid, digest_word_0, digest_word_1, digest_word_2, digest_word_3,
		digest_word_4, digest_word_5, digest_word_6, digest_word_7, output ready);
endinterface

/* hw/rtl/sha256_stream_hasher.sv */
// Streaming SHA-256 hasher top level: one byte or finish per input beat.
// An absorb beat that does not fill a block leaves the input ready for the next beat.
// A beat that fills a block is followed by load, 64 rounds and fold; input waits meanwhile.
// Finish with the marker at byte p: padding runs from p to the end of the block, which is then compressed;
// p >= 56 adds a length block, and a finishing byte that fills a block is compressed before its padding block.
// The digest then waits in the output register. Reset restores the initial hash values.
module sha256_stream_hasher (
	input logic       clk,
	input logic       arst_n,
	sha_in_if.sink    in_ch,
	sha_out_if.source out_ch
);
	sha_pkg::sha_cmd_t    cmd;
	sha_pkg::sha_status_t status;
	sha_pkg::word_t [7:0] hash;
	logic [5:0]           pad_idx, round_idx;
	logic [7:0]           pad_byte;
	logic                 out_load;
	logic                 valid_q;

	sha_ctrl u_ctrl (
		.clk, .arst_n, .in_ch, .out_busy(valid_q && !out_ch.ready), .out_load,
		.status, .cmd, .pad_idx, .pad_byte, .round_idx);

	sha_datapath u_dp (
		.clk, .arst_n, .cmd, .in_byte(in_ch.message_byte), .pad_idx, .pad_byte,
		.round_idx, .status, .hash);

	assign out_ch.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch.digest_word_0 <= hash[0];
			out_ch.digest_word_1 <= hash[1];
			out_ch.digest_word_2 <= hash[2];
			out_ch.digest_word_3 <= hash[3];
			out_ch.digest_word_4 <= hash[4];
			out_ch.digest_word_5 <= hash[5];
			out_ch.digest_word_6 <= hash[6];
			out_ch.digest_word_7 <= hash[7];
		end
	end
endmodule

/* hw/rtl/sha_datapath.sv */
// Bit length, message schedule window and round logic
module sha_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha_pkg::sha_cmd_t    cmd,
	input  logic [7:0]           in_byte,
	input  logic [5:0]           pad_idx,
	input  logic [7:0]           pad_byte,
	input  logic [5:0]           round_idx,
	output sha_pkg::sha_status_t status,
	output sha_pkg::word_t [7:0] hash
);
	logic [63:0]          len_q;
	sha_pkg::word_t [7:0] h_q;
	sha_pkg::word_t [7:0] v_q;
	sha_pkg::word_t       w_q [16];
	sha_pkg::word_t       wr, s0, s1, t1, t2, a2, a15;
	logic [3:0]           ri;
	logic [5:0]           used;
	logic [5:0]           wr_pos;
	logic [7:0]           wr_byte;

	assign used = len_q[8:3];
	assign status.used = used;
	assign status.last_round = (round_idx == 6'd63);
	assign hash = h_q;
	assign ri = round_idx[3:0];

	// pick the byte and its slot for an absorb or padding write
	always_comb begin
		if (cmd.pad_write) begin
			wr_pos = pad_idx;
			wr_byte = cmd.pad_len ? len_q[{~pad_idx[2:0], 3'd0} +: 8] : pad_byte;
		end else begin
			wr_pos = used;
			wr_byte = in_byte;
		end
	end

	always_comb begin
		a2 = w_q[ri - 4'd2];
		a15 = w_q[ri - 4'd15];
		s1 = sha_pkg::ror(a2, 17) ^ sha_pkg::ror(a2, 19) ^ (a2 >> 10);
		s0 = sha_pkg::ror(a15, 7) ^ sha_pkg::ror(a15, 18) ^ (a15 >> 3);
		if (round_idx < 6'd16) begin
			wr = w_q[ri];
		end else begin
			wr = s1 + w_q[ri - 4'd7] + s0 + w_q[ri];
		end
		t1 = v_q[7] + (sha_pkg::ror(v_q[4], 6) ^ sha_pkg::ror(v_q[4], 11)
			^ sha_pkg::ror(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha_pkg::round_k(round_idx) + wr;
		t2 = (sha_pkg::ror(v_q[0], 2) ^ sha_pkg::ror(v_q[0], 13) ^ sha_pkg::ror(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			h_q <= sha_pkg::INIT_HASH;
		end else if (cmd.reset_hash) begin
			h_q <= sha_pkg::INIT_HASH;
			len_q <= '0;
		end else begin
			if (cmd.load_byte) begin
				len_q <= len_q + 64'd8;
			end
			if (cmd.fold) begin
				for (int j = 0; j < 8; j++) begin
					h_q[j] <= h_q[j] + v_q[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			v_q <= h_q;
		end else if (cmd.round) begin
			v_q <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
		end
		if (cmd.load_byte || cmd.pad_write) begin
			// pack bytes big-endian straight into the schedule words
			w_q[wr_pos[5:2]][{~wr_pos[1:0], 3'd0} +: 8] <= wr_byte;
		end else if (cmd.round) begin
			w_q[ri] <= wr;
		end
	end
endmodule

/* hw/rtl/sha_ctrl.sv */
// Sequencer for absorb, padding, compression and digest output
module sha_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	sha_in_if.sink              in_ch,
	input  logic                out_busy,
	output logic                out_load,
	input  sha_pkg::sha_status_t status,
	output sha_pkg::sha_cmd_t   cmd,
	output logic [5:0]          pad_idx,
	output logic [7:0]          pad_byte,
	output logic [5:0]          round_idx
);
	`include "sha256_stream_hasher_assert.svh"

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_FOLD = 3'd3;
	localparam logic [2:0] ST_PAD = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	logic [2:0] state_q;
	logic       fin_q;     // finish pending
	logic       marked_q;  // 0x80 already written
	logic       lenblk_q;  // current compression carries the length
	logic [5:0] pidx_q;
	logic [5:0] rnd_q;
	logic       acc;
	logic       do_byte;
	logic [5:0] pad_start;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign acc = in_ch.valid && in_ch.ready && (in_ch.operation != sha_pkg::OP_UNUSED);
	assign do_byte = acc && (in_ch.operation != sha_pkg::OP_FINISH);
	assign pad_start = do_byte ? status.used + 6'd1 : status.used;
	assign pad_idx = pidx_q;
	assign pad_byte = marked_q ? 8'h00 : 8'h80;
	assign round_idx = rnd_q;
	assign out_load = (state_q == ST_OUT) && !out_busy;

	always_comb begin
		cmd = '0;
		cmd.load_byte = do_byte;
		cmd.pad_write = (state_q == ST_PAD);
		cmd.pad_len = (state_q == ST_PAD) && lenblk_q && (pidx_q >= 6'd56);
		cmd.start = (state_q == ST_START);
		cmd.round = (state_q == ST_ROUND);
		cmd.fold = (state_q == ST_FOLD);
		cmd.reset_hash = out_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q <= 1'b0;
			marked_q <= 1'b0;
			lenblk_q <= 1'b0;
			pidx_q <= '0;
			rnd_q <= '0;
		end else begin
			unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					fin_q <= (in_ch.operation != sha_pkg::OP_ABSORB);
					marked_q <= 1'b0;
					if (do_byte && status.used == 6'd63) begin
						// full block: compress first; on finish, padding follows in a fresh block
						lenblk_q <= 1'b0;
						state_q <= ST_START;
					end else if (in_ch.operation != sha_pkg::OP_ABSORB) begin
						pidx_q <= pad_start;
						// no room for the length after the marker: it gets its own block
						lenblk_q <= (pad_start < 6'd56);
						state_q <= ST_PAD;
					end
				end
			end
			ST_PAD: begin
				marked_q <= 1'b1;
				pidx_q <= pidx_q + 6'd1;
				if (pidx_q == 6'd63) begin
					state_q <= ST_START;
				end
			end
			ST_START: begin
				rnd_q <= '0;
				state_q <= ST_ROUND;
			end
			ST_ROUND: begin
				rnd_q <= rnd_q + 6'd1;
				if (status.last_round) begin
					state_q <= ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (!fin_q) begin
					state_q <= ST_IDLE;
				end else if (lenblk_q) begin
					state_q <= ST_OUT;
				end else begin
					pidx_q <= '0;
					lenblk_q <= 1'b1;
					state_q <= ST_PAD;
				end
			end
			ST_OUT: begin
				if (!out_busy) begin
					state_q <= ST_IDLE;
				end
			end
			default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SHA_ASSERT_IMP(a_ready_idle, in_ch.ready, state_q == ST_IDLE)
	`SHA_ASSERT_NEXT(a_round_adv, state_q == ST_ROUND && !status.last_round, state_q == ST_ROUND)
	`SHA_ASSERT_IMP(a_out_fin, out_load, fin_q && lenblk_q)
endmodule

/* verif/sha256_stream_hasher_checker.sv */
// Digest predictor and scoreboard for the SHA-256 stream hasher
module sha256_stream_hasher_checker (
	input logic clk,
	input logic arst_n,
	sha_in_if.sink in_mon,
	sha_out_if.sink out_mon,
	output int fail_count,
	output int digests_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [255:0] digest_t;

	localparam sha_pkg::word_t [0:63] ROUND_K = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
	localparam sha_pkg::word_t [0:7] START_HASH = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	sha_pkg::word_t chain[8];
	logic [7:0] pending_bytes[64];
	logic [63:0] msg_bits;
	digest_t digest_q[$];

	function automatic sha_pkg::word_t rotr(sha_pkg::word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_pending();
		sha_pkg::word_t w[16];
		sha_pkg::word_t v[8];
		sha_pkg::word_t wr, t1, t2, a2, a15;
		for (int j = 0; j < 16; j++)
			w[j] = {pending_bytes[4*j], pending_bytes[4*j+1], pending_bytes[4*j+2],
				pending_bytes[4*j+3]};
		for (int j = 0; j < 8; j++)
			v[j] = chain[j];
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wr = w[r];
			end else begin
				a2 = w[(r - 2) & 15];
				a15 = w[(r - 15) & 15];
				wr = (rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10)) + w[(r - 7) & 15]
					+ (rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3)) + w[r & 15];
				w[r & 15] = wr;
			end
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wr;
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int j = 7; j > 0; j--)
				v[j] = v[j-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++)
			chain[j] += v[j];
	endtask

	task automatic restart_message();
		for (int j = 0; j < 8; j++)
			chain[j] = START_HASH[j];
		for (int j = 0; j < 64; j++)
			pending_bytes[j] = 8'h00;
		msg_bits = '0;
	endtask

	task automatic absorb_byte(logic [7:0] b);
		int pos;
		pos = int'(msg_bits[8:3]);
		pending_bytes[pos] = b;
		msg_bits += 64'd8;
		if (pos == 63)
			compress_pending();
	endtask

	task automatic hash_beat(logic [1:0] op, logic [7:0] b);
		int pos;
		digest_t d;
		if (op != sha_pkg::OP_ABSORB && op != sha_pkg::OP_ABSORB_FINISH
			&& op != sha_pkg::OP_FINISH)
			return;
		if (op != sha_pkg::OP_FINISH)
			absorb_byte(b);
		if (op == sha_pkg::OP_ABSORB)
			return;
		pos = int'(msg_bits[8:3]);
		pending_bytes[pos] = 8'h80;
		for (int j = pos + 1; j < 64; j++)
			pending_bytes[j] = 8'h00;
		if (pos >= 56) begin
			compress_pending();
			for (int j = 0; j < 56; j++)
				pending_bytes[j] = 8'h00;
		end
		for (int j = 0; j < 8; j++)
			pending_bytes[56 + j] = msg_bits[63 - 8*j -: 8];
		compress_pending();
		d = {chain[0], chain[1], chain[2], chain[3], chain[4], chain[5], chain[6], chain[7]};
		digest_q.push_back(d);
		restart_message();
	endtask

	initial begin
		fail_count = 0;
		digests_pending = 0;
		restart_message();
	end

	always @(posedge clk) begin
		digest_t got, want;
		if (arst_n) begin
			if (in_mon.valid && in_mon.ready)
				hash_beat(in_mon.operation, in_mon.message_byte);
			if (out_mon.valid && out_mon.ready) begin
				got = {out_mon.digest_word_0, out_mon.digest_word_1, out_mon.digest_word_2,
					out_mon.digest_word_3, out_mon.digest_word_4, out_mon.digest_word_5,
					out_mon.digest_word_6, out_mon.digest_word_7};
				if (digest_q.size() == 0) begin
					$display("%0t: unexpected digest %h", $time, got);
					fail_count++;
				end else begin
					want = digest_q.pop_front();
					for (int j = 0; j < 8; j++)
						if (got[255 - 32*j -: 32] !== want[255 - 32*j -: 32]) begin
							$display("%0t: digest_word_%0d expected %h actual %h",
								$time, j, want[255 - 32*j -: 32], got[255 - 32*j -: 32]);
							fail_count++;
						end
				end
			end
		end
		digests_pending = digest_q.size();
	end
endmodule

/* verif/sha256_stream_hasher_test.sv */
// Stimulus, clock and verdict for the SHA-256 stream hasher
module sha256_stream_hasher_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	int fail_count, digests_pending;
	int cycles;
	int beats_sent;
	bit calm_mode;
	bit sink_hold;

	sha_in_if in_ch();
	sha_out_if out_ch();

	sha256_stream_hasher u_top (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	sha256_stream_hasher_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_mon(in_ch), .out_mon(out_ch),
		.fail_count(fail_count), .digests_pending(digests_pending));

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// one beat; returns once accepted
	task automatic send_beat(logic [1:0] op, logic [7:0] b);
		while (!calm_mode && $urandom_range(99) < 31) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.message_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
		beats_sent++;
	endtask

	task automatic send_message(int len, bit tail_byte);
		for (int i = 0; i < len; i++)
			send_beat(sha_pkg::OP_ABSORB, 8'($urandom_range(255)));
		if (tail_byte)
			send_beat(sha_pkg::OP_ABSORB_FINISH, 8'($urandom_range(255)));
		else
			send_beat(sha_pkg::OP_FINISH, 8'($urandom_range(255)));
	endtask

	// let the checker see the last accepted beat before looking at the count
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (digests_pending != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls, one long hold on request
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold) begin
				out_ch.ready <= 1'b0;
				repeat (600) @(posedge clk);
				sink_hold = 1'b0;
			end
			out_ch.ready <= calm_mode || ($urandom_range(99) >= 31);
		end
	end

	initial begin
		int len;
		in_ch.valid = 1'b0;
		in_ch.operation = sha_pkg::OP_ABSORB;
		in_ch.message_byte = 8'h00;
		calm_mode = 1'b0;
		sink_hold = 1'b0;
		beats_sent = 0;
		len = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, extremes, unused code, padding boundaries
		send_beat(sha_pkg::OP_FINISH, 8'hff);
		send_beat(sha_pkg::OP_ABSORB_FINISH, 8'h00);
		send_beat(sha_pkg::OP_ABSORB_FINISH, 8'hff);
		send_beat(sha_pkg::OP_UNUSED, 8'h5a);
		send_beat(sha_pkg::OP_ABSORB, 8'h61);
		send_beat(sha_pkg::OP_UNUSED, 8'ha5);
		send_beat(sha_pkg::OP_ABSORB, 8'h62);
		send_beat(sha_pkg::OP_ABSORB_FINISH, 8'h63);
		drain();
		send_message(55, 1'b0);
		send_message(55, 1'b1);
		send_message(56, 1'b0);
		send_message(63, 1'b1);
		send_message(64, 1'b0);
		drain();

		// long receiver hold while the sender keeps going
		sink_hold = 1'b1;
		for (int i = 0; i < 6; i++)
			send_message($urandom_range(20), 1'($urandom_range(1)));

		// calm stretch with no idling on either side
		calm_mode = 1'b1;
		for (int i = 0; i < 5; i++)
			send_message($urandom_range(70), 1'($urandom_range(1)));
		calm_mode = 1'b0;
		drain();

		while (beats_sent < 1750) begin
			case ($urandom_range(9))
				0: len = 55 + $urandom_range(10);
				1: len = 120 + $urandom_range(140);
				2: send_beat(sha_pkg::OP_UNUSED, 8'($urandom_range(255)));
				default: len = $urandom_range(40);
			endcase
			send_message(len, 1'($urandom_range(1)));
			if ($urandom_range(15) == 0)
				drain();
		end
		drain();
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sha_pkg.sv
hw/rtl/sha_if.sv
hw/rtl/sha_datapath.sv
hw/rtl/sha_ctrl.sv
hw/rtl/sha256_stream_hasher.sv
verif/sha256_stream_hasher_checker.sv
verif/sha256_stream_hasher_test.sv
